### hdl/retro_vm_instruction_core_top_assert.svh
// Assertion macros for the retro VM instruction core.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef RETRO_VM_INSTRUCTION_CORE_TOP_ASSERT_SVH
`define RETRO_VM_INSTRUCTION_CORE_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define RVIC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rvic assertion failed");
`define RVIC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rvic assertion failed");
`else
`define RVIC_ASSERT_IMP(lbl, ante, cons)
`define RVIC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

### hdl/rvic_pkg.sv
package rvic_pkg;

    localparam int MemDepthDefault     = 4096;
    localparam int StackDepthDefault   = 16;
    localparam int ScreenHeightDefault = 32;
    localparam int FontBaseDefault     = 80;
    localparam int ProgramStartDefault = 512;
    localparam int ScreenWidth         = 64;
    localparam int FontLen             = 80;

    // item operations
    localparam logic [1:0] OPN_LOAD = 2'd0;
    localparam logic [1:0] OPN_EXEC = 2'd1;
    localparam logic [1:0] OPN_READ = 2'd2;

    // sequencer steps, also the controller state codes
    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] STEP_CLEAR   = 5'd0;
    localparam logic [STEP_W-1:0] STEP_IDLE    = 5'd1;
    localparam logic [STEP_W-1:0] STEP_LOAD    = 5'd2;
    localparam logic [STEP_W-1:0] STEP_RROW    = 5'd3;
    localparam logic [STEP_W-1:0] STEP_RCAP    = 5'd4;
    localparam logic [STEP_W-1:0] STEP_F1      = 5'd5;
    localparam logic [STEP_W-1:0] STEP_F2      = 5'd6;
    localparam logic [STEP_W-1:0] STEP_F3      = 5'd7;
    localparam logic [STEP_W-1:0] STEP_F4      = 5'd8;
    localparam logic [STEP_W-1:0] STEP_F5      = 5'd9;
    localparam logic [STEP_W-1:0] STEP_EXEC    = 5'd10;
    localparam logic [STEP_W-1:0] STEP_FLAG2   = 5'd11;
    localparam logic [STEP_W-1:0] STEP_RET2    = 5'd12;
    localparam logic [STEP_W-1:0] STEP_DRAW_RD = 5'd13;
    localparam logic [STEP_W-1:0] STEP_DRAW_WR = 5'd14;
    localparam logic [STEP_W-1:0] STEP_DRAW_VF = 5'd15;
    localparam logic [STEP_W-1:0] STEP_BCD     = 5'd16;
    localparam logic [STEP_W-1:0] STEP_SAVE_RD = 5'd17;
    localparam logic [STEP_W-1:0] STEP_SAVE_WR = 5'd18;
    localparam logic [STEP_W-1:0] STEP_LDV_RD  = 5'd19;
    localparam logic [STEP_W-1:0] STEP_LDV_WR  = 5'd20;
    localparam logic [STEP_W-1:0] STEP_FIN     = 5'd21;
    localparam logic [STEP_W-1:0] STEP_DONE    = 5'd22;

    // opcode groups
    localparam logic [3:0] GRP_SYS  = 4'h0;
    localparam logic [3:0] GRP_JP   = 4'h1;
    localparam logic [3:0] GRP_CALL = 4'h2;
    localparam logic [3:0] GRP_SEB  = 4'h3;
    localparam logic [3:0] GRP_SNEB = 4'h4;
    localparam logic [3:0] GRP_SER  = 4'h5;
    localparam logic [3:0] GRP_LDB  = 4'h6;
    localparam logic [3:0] GRP_ADDB = 4'h7;
    localparam logic [3:0] GRP_ALU  = 4'h8;
    localparam logic [3:0] GRP_SNER = 4'h9;
    localparam logic [3:0] GRP_LDI  = 4'hA;
    localparam logic [3:0] GRP_JPV0 = 4'hB;
    localparam logic [3:0] GRP_RND  = 4'hC;
    localparam logic [3:0] GRP_DRW  = 4'hD;
    localparam logic [3:0] GRP_KEY  = 4'hE;
    localparam logic [3:0] GRP_MISC = 4'hF;

    localparam logic [15:0] OP_CLS = 16'h00E0;
    localparam logic [15:0] OP_RET = 16'h00EE;

    localparam logic [3:0] ALU_MOV = 4'h0;
    localparam logic [3:0] ALU_OR  = 4'h1;
    localparam logic [3:0] ALU_AND = 4'h2;
    localparam logic [3:0] ALU_XOR = 4'h3;
    localparam logic [3:0] ALU_ADD = 4'h4;
    localparam logic [3:0] ALU_SUB = 4'h5;
    localparam logic [3:0] ALU_SHR = 4'h6;
    localparam logic [3:0] ALU_SBN = 4'h7;
    localparam logic [3:0] ALU_SHL = 4'hE;

    localparam logic [7:0] KEY_DOWN = 8'h9E;
    localparam logic [7:0] KEY_UP   = 8'hA1;

    localparam logic [7:0] FX_GET_DT = 8'h07;
    localparam logic [7:0] FX_WAIT   = 8'h0A;
    localparam logic [7:0] FX_SET_DT = 8'h15;
    localparam logic [7:0] FX_SET_ST = 8'h18;
    localparam logic [7:0] FX_ADD_I  = 8'h1E;
    localparam logic [7:0] FX_FONT   = 8'h29;
    localparam logic [7:0] FX_BCD    = 8'h33;
    localparam logic [7:0] FX_SAVE   = 8'h55;
    localparam logic [7:0] FX_LOADV  = 8'h65;

    localparam logic [3:0] REG_VF = 4'hF;
    localparam logic [3:0] REG_V0 = 4'h0;

    localparam logic [7:0] FONT_ROM [FontLen] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    typedef struct packed {
        logic [STEP_W-1:0] step;
        logic              accept;
        logic              publish;
    } ctl_cmd_t;

    typedef struct packed {
        logic        clear_last;
        logic [15:0] opcode;
        logic        draw_more;
        logic        cnt_is_x;
        logic        cnt_is_two;
    } dp_stat_t;

endpackage

### hdl/retro_vm_instruction_core_top.sv
// channel | valid     | stall     | payload
// command | cmd_valid | cmd_stall | operation, address, data, keys, random_byte
// result  | rsp_valid | rsp_stall | program_counter, sound_on, waiting_key, row_pixels
//
// One beat in, one beat out. Execute fetches the opcode and operands, then runs it;
// return and flag-setting ALU ops take an extra step, a draw reads and writes each
// drawn row, BCD writes three digits, and save/restore moves V0 through Vx in turn.
// After reset a clearing pass writes the font and zeroes memory; cmd_stall stays
// high meanwhile. A new command is taken while a result waits.
module retro_vm_instruction_core_top
    import rvic_pkg::*;
#(
    parameter int MEM_DEPTH     = MemDepthDefault,
    parameter int STACK_DEPTH   = StackDepthDefault,
    parameter int SCREEN_HEIGHT = ScreenHeightDefault,
    parameter int FONT_BASE     = FontBaseDefault,
    parameter int PROGRAM_START = ProgramStartDefault
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cmd_valid,
    output logic                   cmd_stall,
    input  logic [1:0]             operation,
    input  logic [11:0]            address,
    input  logic [7:0]             data,
    input  logic [15:0]            keys,
    input  logic [7:0]             random_byte,
    output logic                   rsp_valid,
    input  logic                   rsp_stall,
    output logic [11:0]            program_counter,
    output logic                   sound_on,
    output logic                   waiting_key,
    output logic [ScreenWidth-1:0] row_pixels
);

    ctl_cmd_t cmd;
    dp_stat_t status;

    rvic_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .operation (operation),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd),
        .status    (status)
    );

    rvic_datapath #(
        .MEM_DEPTH     (MEM_DEPTH),
        .STACK_DEPTH   (STACK_DEPTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .FONT_BASE     (FONT_BASE),
        .PROGRAM_START (PROGRAM_START)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .address         (address),
        .data            (data),
        .keys            (keys),
        .random_byte     (random_byte),
        .program_counter (program_counter),
        .sound_on        (sound_on),
        .waiting_key     (waiting_key),
        .row_pixels      (row_pixels)
    );

endmodule

### hdl/rvic_datapath.sv
module rvic_datapath
    import rvic_pkg::*;
#(
    parameter int MEM_DEPTH     = MemDepthDefault,
    parameter int STACK_DEPTH   = StackDepthDefault,
    parameter int SCREEN_HEIGHT = ScreenHeightDefault,
    parameter int FONT_BASE     = FontBaseDefault,
    parameter int PROGRAM_START = ProgramStartDefault
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  ctl_cmd_t               cmd,
    output dp_stat_t               status,
    input  logic [11:0]            address,
    input  logic [7:0]             data,
    input  logic [15:0]            keys,
    input  logic [7:0]             random_byte,
    output logic [11:0]            program_counter,
    output logic                   sound_on,
    output logic                   waiting_key,
    output logic [ScreenWidth-1:0] row_pixels
);

    // memory depth and stack depth must be powers of two; the block does not check this
    localparam int AW  = $clog2(MEM_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH);
    localparam int HW  = $clog2(SCREEN_HEIGHT);

    logic [7:0]             mem [MEM_DEPTH];
    logic [7:0]             vmem [16];
    logic [11:0]            stack_mem [STACK_DEPTH];
    logic [ScreenWidth-1:0] disp [SCREEN_HEIGHT];

    logic [AW-1:0]  clr_reg, clr_next;
    logic [11:0]    addr_reg;
    logic [7:0]     data_reg;
    logic [15:0]    keys_reg;
    logic [7:0]     rnd_reg;
    logic [7:0]     op_hi_reg, op_hi_next;
    logic [7:0]     op_lo_reg, op_lo_next;
    logic [7:0]     a_reg, a_next;
    logic [7:0]     b_reg, b_next;
    logic [7:0]     res_reg, res_next;
    logic [11:0]    pc_reg, pc_next;
    logic [15:0]    index_reg, index_next;
    logic [SPW-1:0] sp_reg, sp_next;
    logic [7:0]     delay_reg, delay_next;
    logic [7:0]     sound_reg, sound_next;
    logic [3:0]     cnt_reg, cnt_next;
    logic           flag_reg, flag_next;
    logic           wait_reg, wait_next;
    logic [ScreenWidth-1:0] row_reg, row_next;
    logic [15:0]            vvalid_reg, vvalid_next;
    logic [SCREEN_HEIGHT-1:0] dvalid_reg, dvalid_next;

    logic [7:0]             mem_rd_reg;
    logic [7:0]             v_rd_reg;
    logic [11:0]            st_rd_reg;
    logic [ScreenWidth-1:0] d_rd_reg;

    logic [11:0]      out_pc_reg;
    logic             out_sound_reg;
    logic             out_wait_reg;
    logic [ScreenWidth-1:0] out_row_reg;

    logic                   mem_we;
    logic [AW-1:0]          mem_waddr, mem_raddr;
    logic [7:0]             mem_wdata;
    logic                   v_we;
    logic [3:0]             v_waddr, v_raddr;
    logic [7:0]             v_wdata;
    logic                   st_we;
    logic [SPW-1:0]         st_raddr;
    logic                   d_we;
    logic [HW-1:0]          d_waddr, d_raddr;
    logic [ScreenWidth-1:0] d_wdata;

    logic [15:0]   opcode;
    logic [3:0]    grp, rx, ry, nib;
    logic [7:0]    kk;
    logic [11:0]   nnn;
    logic [11:0]   pc_skip;
    logic [16:0]   pc_inc, idx_sum;
    logic [AW-1:0] mem_pc0, mem_pc1, mem_idx;
    logic          font_hit;
    logic [AW-1:0] font_off;
    logic [7:0]    clr_data;
    logic [5:0]    draw_x;
    logic [HW-1:0] draw_y;
    logic [6:0]    draw_row;
    logic [ScreenWidth-1:0] sprite;
    logic [8:0]    sum9;
    logic [7:0]    bcd_h, bcd_t, bcd_o, bcd_byte;
    logic          key_hit;
    logic          key_any;
    logic [3:0]    key_idx;

    function automatic logic [HW-1:0] y_wrap(input logic [7:0] v);
        logic [9:0] r;
        r = {2'b00, v};
        for (int k = 2; k >= 0; k--) begin
            if (r >= 10'(SCREEN_HEIGHT << k))
            begin
                r = r - 10'(SCREEN_HEIGHT << k);
            end
        end
        return r[HW-1:0];
    endfunction

    assign opcode = {op_hi_reg, op_lo_reg};
    assign grp    = op_hi_reg[7:4];
    assign rx     = op_hi_reg[3:0];
    assign ry     = op_lo_reg[7:4];
    assign nib    = op_lo_reg[3:0];
    assign kk     = op_lo_reg;
    assign nnn    = {op_hi_reg[3:0], op_lo_reg};

    assign pc_skip = pc_reg + 12'd2;
    assign pc_inc  = 17'(pc_reg) + 17'd1;
    assign idx_sum = 17'(index_reg) + 17'(cnt_reg);
    assign mem_pc0 = AW'(pc_reg);
    assign mem_pc1 = pc_inc[AW-1:0];
    assign mem_idx = idx_sum[AW-1:0];

    assign font_hit = (clr_reg >= AW'(FONT_BASE)) && (clr_reg < AW'(FONT_BASE + FontLen));
    assign font_off = clr_reg - AW'(FONT_BASE);
    assign clr_data = font_hit ? FONT_ROM[font_off[6:0]] : 8'h00;

    assign draw_x   = a_reg[5:0];
    assign draw_y   = y_wrap(b_reg);
    assign draw_row = 7'(draw_y) + 7'(cnt_reg);
    assign sprite   = {mem_rd_reg, 56'd0} >> draw_x;
    assign sum9     = {1'b0, a_reg} + {1'b0, b_reg};

    always_comb
    begin
        logic [7:0] rem;
        rem   = a_reg;
        bcd_h = 8'd0;
        bcd_t = 8'd0;
        if (a_reg >= 8'd200)
        begin
            bcd_h = 8'd2;
            rem   = a_reg - 8'd200;
        end
        else if (a_reg >= 8'd100)
        begin
            bcd_h = 8'd1;
            rem   = a_reg - 8'd100;
        end
        if (rem >= 8'd80)
        begin
            rem = rem - 8'd80;
            bcd_t[3] = 1'b1;
        end
        if (rem >= 8'd40)
        begin
            rem = rem - 8'd40;
            bcd_t[2] = 1'b1;
        end
        if (rem >= 8'd20)
        begin
            rem = rem - 8'd20;
            bcd_t[1] = 1'b1;
        end
        if (rem >= 8'd10)
        begin
            rem = rem - 8'd10;
            bcd_t[0] = 1'b1;
        end
        bcd_o = rem;
    end

    assign bcd_byte = (cnt_reg == 4'd0) ? bcd_h : ((cnt_reg == 4'd1) ? bcd_t : bcd_o);
    assign key_hit  = (a_reg < 8'd16) && keys_reg[a_reg[3:0]];

    always_comb
    begin
        key_any = 1'b0;
        key_idx = 4'd0;
        for (int i = 15; i >= 0; i--) begin
            if (keys_reg[i])
            begin
                key_any = 1'b1;
                key_idx = 4'(i);
            end
        end
    end

    assign st_raddr = sp_reg - SPW'(1);
    assign d_raddr  = (cmd.step == STEP_RROW) ? HW'(addr_reg[4:0]) : draw_row[HW-1:0];
    assign mem_raddr = (cmd.step == STEP_F1) ? mem_pc0 :
                       ((cmd.step == STEP_F2) ? mem_pc1 : mem_idx);

    always_comb
    begin
        clr_next    = clr_reg;
        op_hi_next  = op_hi_reg;
        op_lo_next  = op_lo_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        res_next    = res_reg;
        pc_next     = pc_reg;
        index_next  = index_reg;
        sp_next     = sp_reg;
        delay_next  = delay_reg;
        sound_next  = sound_reg;
        cnt_next    = cnt_reg;
        flag_next   = flag_reg;
        wait_next   = wait_reg;
        row_next    = row_reg;
        vvalid_next = vvalid_reg;
        dvalid_next = dvalid_reg;
        mem_we      = 1'b0;
        mem_waddr   = mem_idx;
        mem_wdata   = bcd_byte;
        v_we        = 1'b0;
        v_waddr     = rx;
        v_wdata     = res_reg;
        v_raddr     = rx;
        st_we       = 1'b0;
        d_we        = 1'b0;
        d_waddr     = draw_row[HW-1:0];
        d_wdata     = d_rd_reg ^ sprite;

        if (cmd.accept)
        begin
            wait_next = 1'b0;
            row_next  = '0;
        end

        case (cmd.step)
            STEP_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = clr_data;
                clr_next  = clr_reg + AW'(1);
            end
            STEP_LOAD:
            begin
                mem_we    = 1'b1;
                mem_waddr = AW'(addr_reg);
                mem_wdata = data_reg;
            end
            STEP_RCAP:
            begin
                row_next = d_rd_reg;
            end
            STEP_F2:
            begin
                op_hi_next = mem_rd_reg;
            end
            STEP_F3:
            begin
                op_lo_next = mem_rd_reg;
                v_raddr    = (grp == GRP_JPV0) ? REG_V0 : rx;
                pc_next    = pc_skip;
            end
            STEP_F4:
            begin
                a_next  = v_rd_reg;
                v_raddr = ry;
            end
            STEP_F5:
            begin
                b_next = v_rd_reg;
            end
            STEP_EXEC:
            begin
                case (grp)
                    GRP_SYS:
                    begin
                        if (opcode == OP_CLS)
                        begin
                            dvalid_next = '0;
                        end
                        else if (opcode == OP_RET)
                        begin
                            sp_next = sp_reg - SPW'(1);
                        end
                    end
                    GRP_JP:
                    begin
                        pc_next = nnn;
                    end
                    GRP_CALL:
                    begin
                        st_we   = 1'b1;
                        sp_next = sp_reg + SPW'(1);
                        pc_next = nnn;
                    end
                    GRP_SEB:
                    begin
                        if (a_reg == kk)
                        begin
                            pc_next = pc_skip;
                        end
                    end
                    GRP_SNEB:
                    begin
                        if (a_reg != kk)
                        begin
                            pc_next = pc_skip;
                        end
                    end
                    GRP_SER:
                    begin
                        if (a_reg == b_reg)
                        begin
                            pc_next = pc_skip;
                        end
                    end
                    GRP_LDB:
                    begin
                        v_we    = 1'b1;
                        v_wdata = kk;
                    end
                    GRP_ADDB:
                    begin
                        v_we    = 1'b1;
                        v_wdata = a_reg + kk;
                    end
                    GRP_ALU:
                    begin
                        v_waddr = REG_VF;
                        case (nib)
                            ALU_MOV:
                            begin
                                v_we    = 1'b1;
                                v_waddr = rx;
                                v_wdata = b_reg;
                            end
                            ALU_OR:
                            begin
                                v_we    = 1'b1;
                                v_waddr = rx;
                                v_wdata = a_reg | b_reg;
                            end
                            ALU_AND:
                            begin
                                v_we    = 1'b1;
                                v_waddr = rx;
                                v_wdata = a_reg & b_reg;
                            end
                            ALU_XOR:
                            begin
                                v_we    = 1'b1;
                                v_waddr = rx;
                                v_wdata = a_reg ^ b_reg;
                            end
                            ALU_ADD:
                            begin
                                v_we     = 1'b1;
                                v_wdata  = {7'd0, sum9[8]};
                                res_next = sum9[7:0];
                            end
                            ALU_SUB:
                            begin
                                v_we     = 1'b1;
                                v_wdata  = {7'd0, a_reg > b_reg};
                                res_next = a_reg - b_reg;
                            end
                            ALU_SHR:
                            begin
                                v_we     = 1'b1;
                                v_wdata  = {7'd0, a_reg[0]};
                                res_next = {1'b0, a_reg[7:1]};
                            end
                            ALU_SBN:
                            begin
                                v_we     = 1'b1;
                                v_wdata  = {7'd0, b_reg > a_reg};
                                res_next = b_reg - a_reg;
                            end
                            ALU_SHL:
                            begin
                                v_we     = 1'b1;
                                v_wdata  = {7'd0, a_reg[7]};
                                res_next = {a_reg[6:0], 1'b0};
                            end
                            default:
                            begin
                                v_we = 1'b0;
                            end
                        endcase
                    end
                    GRP_SNER:
                    begin
                        if (a_reg != b_reg)
                        begin
                            pc_next = pc_skip;
                        end
                    end
                    GRP_LDI:
                    begin
                        index_next = {4'd0, nnn};
                    end
                    GRP_JPV0:
                    begin
                        pc_next = nnn + {4'd0, a_reg};
                    end
                    GRP_RND:
                    begin
                        v_we    = 1'b1;
                        v_wdata = rnd_reg & kk;
                    end
                    GRP_DRW:
                    begin
                        flag_next = 1'b0;
                        cnt_next  = 4'd0;
                    end
                    GRP_KEY:
                    begin
                        if ((kk == KEY_DOWN && key_hit) || (kk == KEY_UP && !key_hit))
                        begin
                            pc_next = pc_skip;
                        end
                    end
                    default:
                    begin
                        cnt_next = 4'd0;
                        case (kk)
                            FX_GET_DT:
                            begin
                                v_we    = 1'b1;
                                v_wdata = delay_reg;
                            end
                            FX_WAIT:
                            begin
                                if (key_any)
                                begin
                                    v_we    = 1'b1;
                                    v_wdata = {4'd0, key_idx};
                                end
                                else
                                begin
                                    wait_next = 1'b1;
                                    pc_next   = pc_reg - 12'd2;
                                end
                            end
                            FX_SET_DT:
                            begin
                                delay_next = a_reg;
                            end
                            FX_SET_ST:
                            begin
                                sound_next = a_reg;
                            end
                            FX_ADD_I:
                            begin
                                index_next = index_reg + {8'd0, a_reg};
                            end
                            FX_FONT:
                            begin
                                index_next = 16'(FONT_BASE) + {6'd0, a_reg, 2'b00}
                                             + {8'd0, a_reg};
                            end
                            default:
                            begin
                                v_we = 1'b0;
                            end
                        endcase
                    end
                endcase
            end
            STEP_FLAG2:
            begin
                v_we = 1'b1;
            end
            STEP_RET2:
            begin
                pc_next = st_rd_reg;
            end
            STEP_DRAW_WR:
            begin
                d_we      = 1'b1;
                dvalid_next[draw_row[HW-1:0]] = 1'b1;
                flag_next = flag_reg | (|(d_rd_reg & sprite));
                cnt_next  = cnt_reg + 4'd1;
            end
            STEP_DRAW_VF:
            begin
                v_we    = 1'b1;
                v_waddr = REG_VF;
                v_wdata = {7'd0, flag_reg};
            end
            STEP_BCD:
            begin
                mem_we   = 1'b1;
                cnt_next = cnt_reg + 4'd1;
            end
            STEP_SAVE_RD:
            begin
                v_raddr = cnt_reg;
            end
            STEP_SAVE_WR:
            begin
                mem_we    = 1'b1;
                mem_wdata = v_rd_reg;
                cnt_next  = cnt_reg + 4'd1;
            end
            STEP_LDV_WR:
            begin
                v_we     = 1'b1;
                v_waddr  = cnt_reg;
                v_wdata  = mem_rd_reg;
                cnt_next = cnt_reg + 4'd1;
            end
            STEP_FIN:
            begin
                if (delay_reg != 8'd0)
                begin
                    delay_next = delay_reg - 8'd1;
                end
                if (sound_reg != 8'd0)
                begin
                    sound_next = sound_reg - 8'd1;
                end
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase

        if (v_we)
        begin
            vvalid_next[v_waddr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg    <= '0;
            pc_reg     <= 12'(PROGRAM_START);
            index_reg  <= '0;
            sp_reg     <= '0;
            delay_reg  <= '0;
            sound_reg  <= '0;
            cnt_reg    <= '0;
            flag_reg   <= 1'b0;
            wait_reg   <= 1'b0;
            row_reg    <= '0;
            vvalid_reg <= '0;
            dvalid_reg <= '0;
        end
        else
        begin
            clr_reg    <= clr_next;
            pc_reg     <= pc_next;
            index_reg  <= index_next;
            sp_reg     <= sp_next;
            delay_reg  <= delay_next;
            sound_reg  <= sound_next;
            cnt_reg    <= cnt_next;
            flag_reg   <= flag_next;
            wait_reg   <= wait_next;
            row_reg    <= row_next;
            vvalid_reg <= vvalid_next;
            dvalid_reg <= dvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_hi_reg <= op_hi_next;
        op_lo_reg <= op_lo_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        res_reg   <= res_next;
        if (cmd.accept)
        begin
            addr_reg <= address;
            data_reg <= data;
            keys_reg <= keys;
            rnd_reg  <= random_byte;
        end
        if (cmd.publish)
        begin
            out_pc_reg    <= pc_reg;
            out_sound_reg <= (sound_reg != 8'd0);
            out_wait_reg  <= wait_reg;
            out_row_reg   <= row_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rd_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (v_we)
        begin
            vmem[v_waddr] <= v_wdata;
        end
        v_rd_reg <= vvalid_reg[v_raddr] ? vmem[v_raddr] : 8'd0;
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            stack_mem[sp_reg] <= pc_reg;
        end
        st_rd_reg <= stack_mem[st_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (d_we)
        begin
            disp[d_waddr] <= d_wdata;
        end
        d_rd_reg <= dvalid_reg[d_raddr] ? disp[d_raddr] : '0;
    end

    assign status.clear_last = &clr_reg;
    assign status.opcode     = opcode;
    assign status.draw_more  = (cnt_reg < nib) && (draw_row < 7'(SCREEN_HEIGHT));
    assign status.cnt_is_x   = (cnt_reg == rx);
    assign status.cnt_is_two = (cnt_reg == 4'd2);

    assign program_counter = out_pc_reg;
    assign sound_on        = out_sound_reg;
    assign waiting_key     = out_wait_reg;
    assign row_pixels      = out_row_reg;

endmodule

### hdl/rvic_ctrl.sv
`include "retro_vm_instruction_core_top_assert.svh"
module rvic_ctrl
    import rvic_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_stall,
    input  logic [1:0] operation,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    output ctl_cmd_t   cmd,
    input  dp_stat_t   status
);

    logic [STEP_W-1:0] state_reg, state_next;
    logic              out_valid_reg, out_valid_next;
    logic [3:0]        grp;
    logic [7:0]        kk;

    assign grp = status.opcode[15:12];
    assign kk  = status.opcode[7:0];

    always_comb
    begin
        state_next  = state_reg;
        cmd.step    = state_reg;
        cmd.accept  = 1'b0;
        cmd.publish = 1'b0;
        case (state_reg)
            STEP_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = STEP_IDLE;
                end
            end
            STEP_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd.accept = 1'b1;
                    case (operation)
                        OPN_LOAD: state_next = STEP_LOAD;
                        OPN_EXEC: state_next = STEP_F1;
                        OPN_READ: state_next = STEP_RROW;
                        default:  state_next = STEP_DONE;
                    endcase
                end
            end
            STEP_LOAD:    state_next = STEP_DONE;
            STEP_RROW:    state_next = STEP_RCAP;
            STEP_RCAP:    state_next = STEP_DONE;
            STEP_F1:      state_next = STEP_F2;
            STEP_F2:      state_next = STEP_F3;
            STEP_F3:      state_next = STEP_F4;
            STEP_F4:      state_next = STEP_F5;
            STEP_F5:      state_next = STEP_EXEC;
            STEP_EXEC:
            begin
                state_next = STEP_FIN;
                if (status.opcode == OP_RET)
                begin
                    state_next = STEP_RET2;
                end
                else if (grp == GRP_ALU && (status.opcode[3:0] inside
                         {ALU_ADD, ALU_SUB, ALU_SHR, ALU_SBN, ALU_SHL}))
                begin
                    state_next = STEP_FLAG2;
                end
                else if (grp == GRP_DRW)
                begin
                    state_next = STEP_DRAW_RD;
                end
                else if (grp == GRP_MISC && kk == FX_BCD)
                begin
                    state_next = STEP_BCD;
                end
                else if (grp == GRP_MISC && kk == FX_SAVE)
                begin
                    state_next = STEP_SAVE_RD;
                end
                else if (grp == GRP_MISC && kk == FX_LOADV)
                begin
                    state_next = STEP_LDV_RD;
                end
            end
            STEP_FLAG2:   state_next = STEP_FIN;
            STEP_RET2:    state_next = STEP_FIN;
            STEP_DRAW_RD: state_next = status.draw_more ? STEP_DRAW_WR : STEP_DRAW_VF;
            STEP_DRAW_WR: state_next = STEP_DRAW_RD;
            STEP_DRAW_VF: state_next = STEP_FIN;
            STEP_BCD:     state_next = status.cnt_is_two ? STEP_FIN : STEP_BCD;
            STEP_SAVE_RD: state_next = STEP_SAVE_WR;
            STEP_SAVE_WR: state_next = status.cnt_is_x ? STEP_FIN : STEP_SAVE_RD;
            STEP_LDV_RD:  state_next = STEP_LDV_WR;
            STEP_LDV_WR:  state_next = status.cnt_is_x ? STEP_FIN : STEP_LDV_RD;
            STEP_FIN:     state_next = STEP_DONE;
            STEP_DONE:
            begin
                if (!out_valid_reg || !rsp_stall)
                begin
                    cmd.publish = 1'b1;
                    state_next  = STEP_IDLE;
                end
            end
            default:      state_next = STEP_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !rsp_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.publish)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= STEP_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign cmd_stall = (state_reg != STEP_IDLE);
    assign rsp_valid = out_valid_reg;

    `RVIC_ASSERT_IMP(a_publish_room, cmd.publish, !out_valid_reg || !rsp_stall)
    `RVIC_ASSERT_NXT(a_accept_busy, cmd.accept, state_reg != STEP_IDLE)
    `RVIC_ASSERT_NXT(a_beat_drains, out_valid_reg && !rsp_stall && !cmd.publish, !out_valid_reg)

endmodule

### sim/retro_vm_instruction_core_top_test.sv
module retro_vm_instruction_core_top_test;
    import rvic_pkg::*;

    localparam logic [1:0] OPN_NONE = 2'd3;
    localparam int N_ITEMS = 1300;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct {
        logic [11:0] pc;
        logic        snd;
        logic        wk;
        logic [63:0] row;
    } vm_result_t;

    class vm_scoreboard;
        logic [7:0]  mem [4096];
        logic [7:0]  v [16];
        logic [15:0] idx;
        logic [11:0] pc;
        logic [11:0] stk [16];
        bit          stk_ok [16];
        logic [3:0]  sp;
        logic [7:0]  dt;
        logic [7:0]  st;
        logic [63:0] disp [32];
        vm_result_t  pending_results[$];
        int          errors;

        function new();
            foreach (mem[i]) mem[i] = 8'h00;
            for (int i = 0; i < FontLen; i++) mem[FontBaseDefault + i] = FONT_ROM[i];
            foreach (v[i]) v[i] = 8'h00;
            foreach (stk_ok[i]) stk_ok[i] = 0;
            foreach (disp[i]) disp[i] = 64'd0;
            idx = 16'd0;
            pc = 12'(ProgramStartDefault);
            sp = 4'd0;
            dt = 8'd0;
            st = 8'd0;
            errors = 0;
        endfunction

        function logic [15:0] opcode_at_pc();
            return {mem[pc], mem[pc + 12'd1]};
        endfunction

        function bit step_cpu(logic [15:0] keys, logic [7:0] rnd);
            logic [15:0] op;
            logic [3:0]  x;
            logic [3:0]  y;
            logic [7:0]  kk;
            logic [11:0] nnn;
            logic [7:0]  a;
            logic [7:0]  b;
            logic [5:0]  px;
            logic [4:0]  py;
            logic [63:0] spr;
            bit          wk;
            op = opcode_at_pc();
            x = op[11:8];
            y = op[7:4];
            kk = op[7:0];
            nnn = op[11:0];
            a = v[x];
            b = v[y];
            wk = 0;
            pc = pc + 12'd2;
            case (op[15:12])
                GRP_SYS:
                    if (op == OP_CLS) foreach (disp[i]) disp[i] = 64'd0;
                    else if (op == OP_RET)
                    begin
                        sp = sp - 4'd1;
                        pc = stk[sp];
                    end
                GRP_JP: pc = nnn;
                GRP_CALL:
                begin
                    stk[sp] = pc;
                    stk_ok[sp] = 1;
                    sp = sp + 4'd1;
                    pc = nnn;
                end
                GRP_SEB: if (a == kk) pc = pc + 12'd2;
                GRP_SNEB: if (a != kk) pc = pc + 12'd2;
                GRP_SER: if (a == b) pc = pc + 12'd2;
                GRP_LDB: v[x] = kk;
                GRP_ADDB: v[x] = a + kk;
                GRP_ALU:
                    case (op[3:0])
                        ALU_MOV: v[x] = b;
                        ALU_OR: v[x] = a | b;
                        ALU_AND: v[x] = a & b;
                        ALU_XOR: v[x] = a ^ b;
                        ALU_ADD:
                        begin
                            v[REG_VF] = 8'((9'(a) + 9'(b)) >> 8);
                            v[x] = a + b;
                        end
                        ALU_SUB:
                        begin
                            v[REG_VF] = 8'(a > b);
                            v[x] = a - b;
                        end
                        ALU_SHR:
                        begin
                            v[REG_VF] = 8'(a[0]);
                            v[x] = a >> 1;
                        end
                        ALU_SBN:
                        begin
                            v[REG_VF] = 8'(b > a);
                            v[x] = b - a;
                        end
                        ALU_SHL:
                        begin
                            v[REG_VF] = 8'(a[7]);
                            v[x] = a << 1;
                        end
                        default: ;
                    endcase
                GRP_SNER: if (a != b) pc = pc + 12'd2;
                GRP_LDI: idx = 16'(nnn);
                GRP_JPV0: pc = nnn + 12'(v[REG_V0]);
                GRP_RND: v[x] = rnd & kk;
                GRP_DRW:
                begin
                    px = a[5:0];
                    py = b[4:0];
                    v[REG_VF] = 8'd0;
                    for (int r = 0; r < int'(op[3:0]); r++)
                    begin
                        if (int'(py) + r >= 32) break;
                        spr = {mem[12'(idx + 16'(r))], 56'd0} >> px;
                        if ((disp[int'(py) + r] & spr) != 64'd0) v[REG_VF] = 8'd1;
                        disp[int'(py) + r] ^= spr;
                    end
                end
                GRP_KEY:
                    if (kk == KEY_DOWN && a < 8'd16 && keys[a[3:0]]) pc = pc + 12'd2;
                    else if (kk == KEY_UP && !(a < 8'd16 && keys[a[3:0]])) pc = pc + 12'd2;
                default:
                    case (kk)
                        FX_GET_DT: v[x] = dt;
                        FX_WAIT:
                        begin
                            wk = 1;
                            for (int i = 0; i < 16; i++)
                                if (keys[i])
                                begin
                                    v[x] = 8'(i);
                                    wk = 0;
                                    break;
                                end
                            if (wk) pc = pc - 12'd2;
                        end
                        FX_SET_DT: dt = a;
                        FX_SET_ST: st = a;
                        FX_ADD_I: idx = idx + 16'(a);
                        FX_FONT: idx = 16'(FontBaseDefault) + 16'd5 * 16'(a);
                        FX_BCD:
                        begin
                            mem[idx[11:0]] = a / 8'd100;
                            mem[12'(idx + 16'd1)] = (a / 8'd10) % 8'd10;
                            mem[12'(idx + 16'd2)] = a % 8'd10;
                        end
                        FX_SAVE:
                            for (int i = 0; i <= int'(x); i++) mem[12'(idx + 16'(i))] = v[i];
                        FX_LOADV:
                            for (int i = 0; i <= int'(x); i++) v[i] = mem[12'(idx + 16'(i))];
                        default: ;
                    endcase
            endcase
            if (dt != 8'd0) dt = dt - 8'd1;
            if (st != 8'd0) st = st - 8'd1;
            return wk;
        endfunction

        function void accept_cmd(logic [1:0] opn, logic [11:0] addr, logic [7:0] dat,
                                 logic [15:0] keys, logic [7:0] rnd);
            vm_result_t res;
            res.wk = 0;
            res.row = 64'd0;
            if (opn == OPN_LOAD) mem[addr] = dat;
            else if (opn == OPN_EXEC) res.wk = step_cpu(keys, rnd);
            else if (opn == OPN_READ) res.row = disp[addr[4:0]];
            res.pc = pc;
            res.snd = (st != 8'd0);
            pending_results.push_back(res);
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            errors++;
            $display("mismatch %s: got %h expected %h", what, got, want);
        endtask

        task check_beat(logic [11:0] pc_o, logic snd, logic wk, logic [63:0] row);
            vm_result_t want;
            if (pending_results.size() == 0)
            begin
                report("unexpected beat", 64'(pc_o), 64'd0);
                return;
            end
            want = pending_results.pop_front();
            if (pc_o !== want.pc) report("program_counter", 64'(pc_o), 64'(want.pc));
            if (snd !== want.snd) report("sound_on", 64'(snd), 64'(want.snd));
            if (wk !== want.wk) report("waiting_key", 64'(wk), 64'(want.wk));
            if (row !== want.row) report("row_pixels", row, want.row);
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        cmd_valid;
    logic        cmd_stall;
    logic [1:0]  operation;
    logic [11:0] address;
    logic [7:0]  data;
    logic [15:0] keys;
    logic [7:0]  random_byte;
    logic        rsp_valid;
    logic        rsp_stall;
    logic [11:0] program_counter;
    logic        sound_on;
    logic        waiting_key;
    logic [63:0] row_pixels;

    vm_scoreboard vm = new();
    int sent = 0;
    int beats = 0;
    int hold = 0;
    int cycles = 0;

    retro_vm_instruction_core_top u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .operation(operation),
        .address(address),
        .data(data),
        .keys(keys),
        .random_byte(random_byte),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .program_counter(program_counter),
        .sound_on(sound_on),
        .waiting_key(waiting_key),
        .row_pixels(row_pixels)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result side: one draw of stall cycles per beat, one long hold to back up the core
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                vm.check_beat(program_counter, sound_on, waiting_key, row_pixels);
                beats++;
                if (beats == 300) hold = 400;
                else if (beats % 150 < 30) hold = 0;
                else hold = $urandom_range(0, 14);
            end
            if (hold > 0)
            begin
                rsp_stall <= 1'b1;
                hold--;
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    task automatic send(logic [1:0] opn, logic [11:0] addr, logic [7:0] dat, logic [15:0] k);
        int gap;
        logic [7:0] rnd;
        gap = (sent % 200 < 40) ? 0 : $urandom_range(0, 14);
        rnd = 8'($urandom);
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        operation <= opn;
        address <= addr;
        data <= dat;
        keys <= k;
        random_byte <= rnd;
        do @(posedge clk); while (cmd_stall);
        vm.accept_cmd(opn, addr, dat, k, rnd);
        sent++;
    endtask

    function automatic logic [15:0] rand_keys();
        case ($urandom_range(0, 3))
            0: return 16'd0;
            1: return 16'd1 << $urandom_range(0, 15);
            default: return 16'($urandom);
        endcase
    endfunction

    // never return through a stack slot that no call has filled
    task automatic exec_here(logic [15:0] k);
        if (vm.opcode_at_pc() == OP_RET && !vm.stk_ok[vm.sp - 4'd1])
            send(OPN_LOAD, vm.pc + 12'd1, OP_CLS[7:0], rand_keys());
        send(OPN_EXEC, 12'($urandom), 8'($urandom), k);
    endtask

    task automatic run_instr(logic [15:0] instr, logic [15:0] k);
        send(OPN_LOAD, vm.pc, instr[15:8], rand_keys());
        send(OPN_LOAD, vm.pc + 12'd1, instr[7:0], rand_keys());
        exec_here(k);
    endtask

    function automatic logic [15:0] rand_instr();
        logic [3:0] grp;
        logic [15:0] w;
        logic [7:0] fx [9];
        fx = '{FX_GET_DT, FX_WAIT, FX_SET_DT, FX_SET_ST, FX_ADD_I, FX_FONT,
               FX_BCD, FX_SAVE, FX_LOADV};
        grp = 4'($urandom);
        w = 16'($urandom);
        if ($urandom_range(0, 1)) w[7:0] = 8'($urandom_range(0, 15));
        w[15:12] = grp;
        case (grp)
            GRP_SYS:
                case ($urandom_range(0, 2))
                    0: w = OP_CLS;
                    1: w = OP_RET;
                    default: ;
                endcase
            GRP_KEY:
                case ($urandom_range(0, 4))
                    0, 1: w[7:0] = KEY_DOWN;
                    2, 3: w[7:0] = KEY_UP;
                    default: ;
                endcase
            GRP_MISC:
                if ($urandom_range(0, 7) != 0) w[7:0] = fx[$urandom_range(0, 8)];
            default: ;
        endcase
        return w;
    endfunction

    initial
    begin
        rst_n = 1'b0;
        cmd_valid = 1'b0;
        operation = OPN_LOAD;
        address = 12'd0;
        data = 8'd0;
        keys = 16'd0;
        random_byte = 8'd0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        send(OPN_NONE, 12'hFFF, 8'hFF, 16'hFFFF);
        send(OPN_READ, 12'h000, 8'h00, 16'h0000);
        run_instr(16'h6AFF, 16'h0000);
        run_instr(16'h6B01, 16'h0000);
        run_instr(16'h8AB4, 16'h0000);
        run_instr(16'h8AB5, 16'h0000);
        run_instr(16'hFF0A, 16'h0000);
        run_instr(16'hFF0A, 16'h8000);
        run_instr(16'hDAB5, 16'h0000);
        run_instr(16'hEF9E, 16'h8000);
        send(OPN_READ, 12'hFFF, 8'h00, 16'h0000);

        while (sent < N_ITEMS)
        begin
            int r;
            r = $urandom_range(0, 99);
            if (r < 70) run_instr(rand_instr(), rand_keys());
            else if (r < 80) send(OPN_READ, 12'($urandom), 8'($urandom), rand_keys());
            else if (r < 84) send(OPN_NONE, 12'($urandom), 8'($urandom), rand_keys());
            else if (r < 93) exec_here(rand_keys());
            else send(OPN_LOAD, 12'($urandom), 8'($urandom), rand_keys());
        end
        cmd_valid <= 1'b0;

        while (vm.pending_results.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
        if (vm.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
